// ===== rtl/xbd_pkg.sv =====
// Package: shared types, constants and helpers for the bounded-draw generator.
`timescale 1ns / 1ps
package xbd_pkg;

   localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MIX1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MIX2  = 64'h94d049bb133111eb;

   typedef enum logic [2:0] {
      OP_RAW64   = 3'd0,
      OP_RAW32   = 3'd1,
      OP_BND32   = 3'd2,
      OP_BND64   = 3'd3,
      OP_RNG32   = 3'd4,
      OP_RNG64   = 3'd5,
      OP_BIT     = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_SEED_ADD,
      ST_SEED_M1,
      ST_SEED_M2,
      ST_SEED_FIN,
      ST_IDLE,
      ST_DRAW,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_REDRAW,
      ST_RESULT
   } state_type;

   // multiplier request: a 64x64 product split into 32x32 partial products
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] rem;
   } div_rsp_type;

   function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned k);
      logic [127:0] d;
      d = {v, v} << k;
      return d[127:64];
   endfunction

endpackage

// ===== rtl/xbd_mul.sv =====
// Shared 64x64 multiplier, one 32x32 partial product per cycle.
`timescale 1ns / 1ps
module xbd_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  xbd_pkg::mul_req_type req,
   output xbd_pkg::mul_rsp_type rsp
);
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [31:0]  op_a, op_b;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   always_comb begin
      op_a  = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      op_b  = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp    = {32'd0, op_a} * {32'd0, op_b};
      pp_sh = {64'd0, pp} << ({5'd0, step_ff[1]} + {5'd0, step_ff[0]}) * 7'd32;
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_sh;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd3) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = busy_ff && step_ff == 3'd4 ? 1'b0 : (!busy_ff && step_ff == 3'd4);
   assign rsp.prod = acc_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= 3'd3) else $error("mul step overrun");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.done) |-> $past(busy_ff)) else $error("mul done without work");
   assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff && step_ff == 3'd0) else $error("mul start lost");
endmodule

// ===== rtl/xbd_div.sv =====
// Shared restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module xbd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  xbd_pkg::div_req_type req,
   output xbd_pkg::div_rsp_type rsp
);
   logic [63:0] num_ff, num_in, den_ff, den_in;
   logic [64:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      trial   = {rem_ff[63:0], num_ff[63]};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         rem_in = trial >= {1'b0, den_ff} ? trial - {1'b0, den_ff} : trial;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[63:0];

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("div done while busy");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff[63:0] < den_ff) else $error("div remainder too large");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 7'd63) else $error("div count overrun");
endmodule

// ===== rtl/xoshiro256pp_bounded_draws_unit.sv =====
// Top level: xoshiro256++ generator with Lemire bounded and range draws.
`timescale 1ns / 1ps
// channel | ports                                  | direction
// req     | req_valid req_stall req_operation/...  | in, stall out
// rsp     | rsp_valid rsp_stall rsp_value          | out, stall in
// csr     | csr_write_enable csr_write_data        | in, write only
// Raw and bit draws, and maximum bounds, pass from accept through the draw state
// to the result. Bounded draws take one draw through the 4-step multiplier and
// one more draw per rejected draw, plus the threshold remainder through the
// divider when the low product word first falls below the span.
// Reset and each seed write run a 4-word SplitMix64 pass
// with req_stall high. A result holds in rsp_value until taken; req_stall is
// high from accept until the result is taken.
module xoshiro256pp_bounded_draws_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [63:0] req_bound,
   input  logic signed [63:0] req_low_end,
   input  logic signed [63:0] req_high_end,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value
);
   xbd_pkg::state_type   state_ff, state_in;
   xbd_pkg::op_type      op_ff, op_in;
   xbd_pkg::mul_req_type mreq;
   xbd_pkg::mul_rsp_type mrsp;
   xbd_pkg::div_req_type dreq;
   xbd_pkg::div_rsp_type drsp;

   logic [63:0] w0_ff, w1_ff, w2_ff, w3_ff, w0_in, w1_in, w2_in, w3_in;
   logic [63:0] acc_ff, acc_in, z_ff, z_in;
   logic [1:0]  widx_ff, widx_in;
   logic [63:0] span_ff, span_in, base_ff, base_in, lim_ff, lim_in;
   logic [63:0] val_ff, val_in;
   logic        wide_ff, wide_in, haslim_ff, haslim_in;

   logic [63:0] nx0, nx1, nx2, nx3, out_d, t2, t3, zfin;
   logic [63:0] mul_frac, mul_hi, nspan;
   logic        is32;

   always_comb begin
      out_d = xbd_pkg::rotl(w0_ff + w3_ff, 23) + w0_ff;
      t2    = w2_ff ^ w0_ff;
      t3    = w3_ff ^ w1_ff;
      nx1   = w1_ff ^ t2;
      nx0   = w0_ff ^ t3;
      nx2   = t2 ^ (w1_ff << 17);
      nx3   = xbd_pkg::rotl(t3, 45);
      zfin  = mrsp.prod[63:0] ^ (mrsp.prod[63:0] >> 31);
      is32  = !wide_ff;
      mul_frac = is32 ? {32'd0, mrsp.prod[31:0]} : mrsp.prod[63:0];
      mul_hi   = is32 ? {32'd0, mrsp.prod[63:32]} : mrsp.prod[127:64];
      nspan    = is32 ? {32'd0, 32'd0 - span_ff[31:0]} : 64'd0 - span_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xbd_pkg::ST_SEED_ADD: state_in = xbd_pkg::ST_SEED_M1;
         xbd_pkg::ST_SEED_M1:  if (mrsp.done) state_in = xbd_pkg::ST_SEED_M2;
         xbd_pkg::ST_SEED_M2:  if (mrsp.done) state_in = xbd_pkg::ST_SEED_FIN;
         xbd_pkg::ST_SEED_FIN:
            state_in = widx_ff == 2'd3 ? xbd_pkg::ST_IDLE : xbd_pkg::ST_SEED_ADD;
         xbd_pkg::ST_IDLE:     if (req_valid) state_in = xbd_pkg::ST_DRAW;
         xbd_pkg::ST_DRAW: begin
            if (op_ff == xbd_pkg::OP_NONE || op_ff == xbd_pkg::OP_RAW64 ||
                op_ff == xbd_pkg::OP_RAW32 || op_ff == xbd_pkg::OP_BIT ||
                span_ff == 64'd0)
               state_in = xbd_pkg::ST_RESULT;
            else
               state_in = xbd_pkg::ST_MUL;
         end
         xbd_pkg::ST_MUL:    if (mrsp.done) state_in = xbd_pkg::ST_CHECK;
         xbd_pkg::ST_CHECK: begin
            if (mul_frac >= span_ff) state_in = xbd_pkg::ST_RESULT;
            else if (!haslim_ff) state_in = xbd_pkg::ST_DIV;
            else if (mul_frac < lim_ff) state_in = xbd_pkg::ST_REDRAW;
            else state_in = xbd_pkg::ST_RESULT;
         end
         xbd_pkg::ST_DIV: begin
            if (drsp.done)
               state_in = mul_frac < drsp.rem ? xbd_pkg::ST_REDRAW : xbd_pkg::ST_RESULT;
         end
         xbd_pkg::ST_REDRAW: state_in = xbd_pkg::ST_MUL;
         xbd_pkg::ST_RESULT: if (!rsp_stall) state_in = xbd_pkg::ST_IDLE;
         default:            state_in = xbd_pkg::ST_IDLE;
      endcase
      if (csr_write_enable) state_in = xbd_pkg::ST_SEED_ADD;
   end

   // datapath and outputs
   always_comb begin
      w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff; w3_in = w3_ff;
      acc_in = acc_ff; z_in = z_ff; widx_in = widx_ff;
      op_in = op_ff; span_in = span_ff; base_in = base_ff; lim_in = lim_ff;
      val_in = val_ff; wide_in = wide_ff;
      haslim_in = haslim_ff;
      mreq = '0;
      dreq = '0;
      unique case (state_ff)
         xbd_pkg::ST_SEED_ADD: begin
            acc_in = acc_ff + xbd_pkg::SM_GAMMA;
            mreq.start = 1'b1;
            mreq.a = (acc_ff + xbd_pkg::SM_GAMMA) ^ ((acc_ff + xbd_pkg::SM_GAMMA) >> 30);
            mreq.b = xbd_pkg::SM_MIX1;
         end
         xbd_pkg::ST_SEED_M1: begin
            if (mrsp.done) begin
               mreq.start = 1'b1;
               mreq.a = mrsp.prod[63:0] ^ (mrsp.prod[63:0] >> 27);
               mreq.b = xbd_pkg::SM_MIX2;
            end
         end
         xbd_pkg::ST_SEED_M2: if (mrsp.done) z_in = zfin;
         xbd_pkg::ST_SEED_FIN: begin
            unique case (widx_ff)
               2'd0: w0_in = z_ff;
               2'd1: w1_in = z_ff;
               2'd2: w2_in = z_ff;
               2'd3: w3_in = z_ff;
               default: w3_in = z_ff;
            endcase
            widx_in = widx_ff + 2'd1;
         end
         xbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in = xbd_pkg::op_type'(req_operation);
               haslim_in = 1'b0;
               unique case (xbd_pkg::op_type'(req_operation))
                  xbd_pkg::OP_BND32: begin
                     wide_in = 1'b0; base_in = '0;
                     span_in = {32'd0, req_bound[31:0] + 32'd1};
                  end
                  xbd_pkg::OP_BND64: begin
                     wide_in = 1'b1; base_in = '0; span_in = req_bound + 64'd1;
                  end
                  xbd_pkg::OP_RNG32: begin
                     wide_in = 1'b0; base_in = {32'd0, req_low_end[31:0]};
                     span_in = {32'd0, req_high_end[31:0] - req_low_end[31:0] + 32'd1};
                  end
                  xbd_pkg::OP_RNG64: begin
                     wide_in = 1'b1; base_in = req_low_end;
                     span_in = req_high_end - req_low_end + 64'd1;
                  end
                  default: begin
                     wide_in = 1'b1; base_in = '0; span_in = '0;
                  end
               endcase
            end
         end
         xbd_pkg::ST_DRAW: begin
            if (op_ff != xbd_pkg::OP_NONE) begin
               w0_in = nx0; w1_in = nx1; w2_in = nx2; w3_in = nx3;
            end
            unique case (op_ff)
               xbd_pkg::OP_RAW64: val_in = out_d;
               xbd_pkg::OP_RAW32: val_in = {32'd0, out_d[63:32]};
               xbd_pkg::OP_BIT:   val_in = {63'd0, out_d[63]};
               xbd_pkg::OP_NONE:  val_in = '0;
               default: begin
                  // span wrapped to zero: full-width draw
                  if (wide_ff) val_in = base_ff + out_d;
                  else val_in = {32'd0, base_ff[31:0] + out_d[63:32]};
               end
            endcase
            mreq.start = 1'b1;
            mreq.a = wide_ff ? out_d : {32'd0, out_d[63:32]};
            mreq.b = span_ff;
         end
         xbd_pkg::ST_MUL: ;
         xbd_pkg::ST_CHECK: begin
            if (wide_ff) val_in = base_ff + mul_hi;
            else val_in = {32'd0, base_ff[31:0] + mul_hi[31:0]};
            if (mul_frac < span_ff && !haslim_ff) begin
               dreq.start = 1'b1;
               dreq.num = nspan;
               dreq.den = span_ff;
            end
         end
         xbd_pkg::ST_DIV: begin
            if (drsp.done) begin
               lim_in = drsp.rem;
               haslim_in = 1'b1;
            end
         end
         xbd_pkg::ST_REDRAW: begin
            w0_in = nx0; w1_in = nx1; w2_in = nx2; w3_in = nx3;
            mreq.start = 1'b1;
            mreq.a = wide_ff ? out_d : {32'd0, out_d[63:32]};
            mreq.b = span_ff;
         end
         xbd_pkg::ST_RESULT: ;
         default: ;
      endcase
      if (csr_write_enable) begin
         acc_in = csr_write_data;
         widx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xbd_pkg::ST_SEED_ADD;
         widx_ff  <= '0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         acc_ff   <= acc_in;
      end
      w0_ff <= w0_in; w1_ff <= w1_in; w2_ff <= w2_in; w3_ff <= w3_in;
      z_ff <= z_in; op_ff <= op_in; span_ff <= span_in; base_ff <= base_in;
      lim_ff <= lim_in; val_ff <= val_in;
      wide_ff <= wide_in; haslim_ff <= haslim_in;
   end

   xbd_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   xbd_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign req_stall = state_ff != xbd_pkg::ST_IDLE || csr_write_enable;
   assign rsp_valid = state_ff == xbd_pkg::ST_RESULT;
   assign rsp_value = val_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && !csr_write_enable |=> rsp_valid && $stable(rsp_value))
      else $error("result lost under stall");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == xbd_pkg::ST_CHECK |-> $past(mrsp.done)) else $error("check before product");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == xbd_pkg::ST_REDRAW |-> haslim_ff) else $error("redraw without threshold");
endmodule

// ===== test/xoshiro256pp_bounded_draws_unit_tb.sv =====
// Testbench for the xoshiro256++ bounded-draw unit: directed and random draws against a predictor.
`timescale 1ns / 1ps
module xoshiro256pp_bounded_draws_unit_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic [63:0] req_bound = '0;
   logic signed [63:0] req_low_end = '0;
   logic signed [63:0] req_high_end = '0;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;

   logic [63:0] gen_state [4];
   logic [63:0] pending_values [$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles = 0;

   xoshiro256pp_bounded_draws_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_bound(req_bound),
      .req_low_end(req_low_end), .req_high_end(req_high_end),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rot_word(input logic [63:0] v, input int k);
      return (v << k) | (v >> (64 - k));
   endfunction

   task automatic reseed_state(input logic [63:0] s);
      logic [63:0] acc, z;
      acc = s;
      for (int i = 0; i < 4; i++) begin
         acc = acc + xbd_pkg::SM_GAMMA;
         z = acc;
         z = (z ^ (z >> 30)) * xbd_pkg::SM_MIX1;
         z = (z ^ (z >> 27)) * xbd_pkg::SM_MIX2;
         gen_state[i] = z ^ (z >> 31);
      end
   endtask

   function automatic logic [63:0] next_draw();
      logic [63:0] result, sh;
      result = rot_word(gen_state[0] + gen_state[3], 23) + gen_state[0];
      sh = gen_state[1] << 17;
      gen_state[2] ^= gen_state[0];
      gen_state[3] ^= gen_state[1];
      gen_state[1] ^= gen_state[2];
      gen_state[0] ^= gen_state[3];
      gen_state[2] ^= sh;
      gen_state[3] = rot_word(gen_state[3], 45);
      return result;
   endfunction

   function automatic logic [31:0] draw_below32(input logic [31:0] maxv);
      logic [31:0] span, limit;
      logic [63:0] prod, d;
      if (maxv == '1) begin
         d = next_draw();
         return d[63:32];
      end
      span = maxv + 32'd1;
      prod = (next_draw() >> 32) * {32'd0, span};
      if (prod[31:0] < span) begin
         limit = (32'd0 - span) % span;
         while (prod[31:0] < limit) prod = (next_draw() >> 32) * {32'd0, span};
      end
      return prod[63:32];
   endfunction

   function automatic logic [63:0] draw_below64(input logic [63:0] maxv);
      logic [63:0] span, limit;
      logic [127:0] prod;
      if (maxv == '1) return next_draw();
      span = maxv + 64'd1;
      prod = {64'd0, next_draw()} * {64'd0, span};
      if (prod[63:0] < span) begin
         limit = (64'd0 - span) % span;
         while (prod[63:0] < limit) prod = {64'd0, next_draw()} * {64'd0, span};
      end
      return prod[127:64];
   endfunction

   function automatic logic [63:0] predict_value(input xbd_pkg::op_type op,
                                                 input logic [63:0] bnd,
                                                 input logic [63:0] lo, input logic [63:0] hi);
      logic [31:0] r32;
      case (op)
         xbd_pkg::OP_RAW64: return next_draw();
         xbd_pkg::OP_RAW32: return next_draw() >> 32;
         xbd_pkg::OP_BND32: return {32'd0, draw_below32(bnd[31:0])};
         xbd_pkg::OP_BND64: return draw_below64(bnd);
         xbd_pkg::OP_RNG32: begin
            r32 = lo[31:0] + draw_below32(hi[31:0] - lo[31:0]);
            return {32'd0, r32};
         end
         xbd_pkg::OP_RNG64: return lo + draw_below64(hi - lo);
         xbd_pkg::OP_BIT: return next_draw() >> 63;
         default: return 64'd0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_item(input xbd_pkg::op_type op, input logic [63:0] bnd,
                            input logic [63:0] lo, input logic [63:0] hi);
      while (($urandom_range(99) < send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_bound <= bnd;
      req_low_end <= lo;
      req_high_end <= hi;
      pending_values.push_back(predict_value(op, bnd, lo, hi));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] s);
      wait_drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= s;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reseed_state(s);
      repeat (60) @(posedge clock);
   endtask

   // receiver stall, result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_values.size() == 0)
               report_mismatch($sformatf("unexpected item value=%h", rsp_value));
            else if (pending_values.pop_front() !== rsp_value)
               report_mismatch($sformatf("value mismatch got=%h", rsp_value));
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("xoshiro256pp_bounded_draws_unit test failed");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_word();
      case ($urandom_range(5))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return {32'd0, $urandom()};
         default: return rand64();
      endcase
   endfunction

   task automatic test_directed();
      send_item(xbd_pkg::OP_RAW64, 64'd0, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_RAW32, '1, '1, '1);
      send_item(xbd_pkg::OP_BIT, 64'd0, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND32, 64'd0, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND32, 64'hffff_ffff, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND32, 64'h8000_0000, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND32, 64'h0000_0002, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND64, 64'd0, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND64, '1, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND64, 64'h8000_0000_0000_0000, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_BND64, 64'h5555_5555_5555_5555, 64'd0, 64'd0);
      send_item(xbd_pkg::OP_RNG32, 64'd0, -64'sd10, 64'sd10);
      send_item(xbd_pkg::OP_RNG32, 64'd0, 64'h8000_0000, 64'h7fff_ffff);
      send_item(xbd_pkg::OP_RNG32, 64'd0, 64'sd100, 64'sd5);
      send_item(xbd_pkg::OP_RNG64, 64'd0, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
      send_item(xbd_pkg::OP_RNG64, 64'd0, -64'sd3, 64'sd3);
      send_item(xbd_pkg::OP_RNG64, 64'd0, 64'sd50, -64'sd50);
      send_item(xbd_pkg::OP_RNG64, 64'd0, 64'sd7, 64'sd7);
      send_item(xbd_pkg::OP_NONE, '1, '1, '1);
      send_item(xbd_pkg::OP_RAW64, 64'd0, 64'd0, 64'd0);
   endtask

   task automatic test_random(input int count);
      xbd_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         op = xbd_pkg::op_type'($urandom_range(7));
         send_item(op, edge_word(), edge_word(), edge_word());
      end
   endtask

   initial begin
      reseed_state(64'd0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (60) @(posedge clock);
      test_directed();
      send_idle_pct = 11; recv_idle_pct = 67;
      test_random(600);
      write_seed('1);
      send_idle_pct = 67; recv_idle_pct = 11;
      test_random(600);
      write_seed(rand64());
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(350);
      write_seed(64'd0);
      test_random(350);
      wait_drain();
      if (error_count == 0) begin
         $display("xoshiro256pp_bounded_draws_unit test passed");
      end else begin
         $display("xoshiro256pp_bounded_draws_unit test failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/xbd_pkg.sv
rtl/xbd_mul.sv
rtl/xbd_div.sv
rtl/xoshiro256pp_bounded_draws_unit.sv
test/xoshiro256pp_bounded_draws_unit_tb.sv
